>>> src/supd_pkg.sv
// Shared types and constants for the step unit pulse debouncer.
// Used by supd_vote and step_unit_pulse_debouncer; no dependencies.

package supd_pkg;

  localparam int unsigned WINDOW_DEPTH = 16;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned RAW_W      = 8;
  localparam int unsigned ACC_W      = 20;
  localparam int unsigned TGT_W      = 16;
  localparam int unsigned AVG_W      = 24;
  localparam int unsigned ECNT_W     = 2;
  localparam int unsigned RATIO_W    = 8;
  localparam int unsigned DWIN_W     = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MUL_A_W    = 24;
  localparam int unsigned MUL_B_W    = 8;
  localparam int unsigned MUL_W      = MUL_A_W + MUL_B_W;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 40;

  localparam logic [ACC_W-1:0]   ACC_MAX     = '1;
  localparam logic [STEP_W-1:0]  STEP_MAX    = '1;
  localparam logic [TGT_W-1:0]   TGT_MAX     = '1;
  localparam logic [ECNT_W-1:0]  ECNT_MAX    = '1;
  localparam logic [MUL_B_W-1:0] ALPHA_Q8    = 8'd26;
  localparam logic [MUL_B_W-1:0] ALPHA_INV_Q8 = 8'd230;

  localparam logic [15:0]        SPU_RST     = 16'd200;
  localparam logic [15:0]        MAXDEV_RST  = 16'd20;
  localparam logic               ADAPT_RST   = 1'b0;
  localparam logic [RATIO_W-1:0] RATIO_RST   = 8'd26;
  localparam logic [DWIN_W-1:0]  DWIN_RST    = 5'd5;
  localparam logic [15:0]        CLEN_RST    = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP       = 3'd0,
    CMD_SIGNAL     = 3'd1,
    CMD_CAL_START  = 3'd2,
    CMD_CAL_FINISH = 3'd3,
    CMD_RESET      = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE       = 3'd0,
    ST_SIGNAL     = 3'd1,
    ST_DEV_ERR    = 3'd2,
    ST_CAL_UPD    = 3'd3,
    ST_CAL_REJECT = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPU    = 3'd0,
    CFG_MAXDEV = 3'd1,
    CFG_ADAPT  = 3'd2,
    CFG_RATIO  = 3'd3,
    CFG_DWIN   = 3'd4,
    CFG_CLEN   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VOTE_ZERO    = 2'd0,
    VOTE_ONE     = 2'd1,
    VOTE_ABSTAIN = 2'd2
  } vote_e;

  typedef struct packed {
    logic  push;
    logic  clear;
    vote_e vote;
  } vote_req_t;

  typedef struct packed {
    logic done;
    logic emit;
    logic level;
  } vote_rsp_t;

endpackage

>>> src/supd_vote.sv
// Majority-vote window: sample memory, serial vote counter and change detector.
// Depends on supd_pkg.

module supd_vote #(
  parameter int unsigned WINDOW_DEPTH = supd_pkg::WINDOW_DEPTH,
  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int unsigned SZ_W  = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  supd_pkg::vote_req_t req_i,
  input  logic [SZ_W-1:0]     size_i,
  output supd_pkg::vote_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    V_IDLE = 3'b001,
    V_CNT  = 3'b010,
    V_DEC  = 3'b100
  } vstate_e;

  vstate_e             state_q, state_d;
  logic [IDX_W-1:0]    widx_q, widx_d;
  logic [SZ_W-1:0]     fill_q, fill_d;
  logic [SZ_W-1:0]     ptr_q, ptr_d;
  logic [SZ_W-1:0]     c0_q, c0_d;
  logic [SZ_W-1:0]     c1_q, c1_d;
  logic                known_q, known_d;
  logic                last_q, last_d;
  logic                rvld_q, rvld_d;
  supd_pkg::vote_rsp_t rsp_q, rsp_d;

  supd_pkg::vote_e     mem [WINDOW_DEPTH];
  supd_pkg::vote_e     rd_q;
  logic                wr_en, rd_en;
  logic [SZ_W-1:0]     widx_inc;
  logic                v;

  assign wr_en    = (state_q == V_IDLE) && req_i.push && !req_i.clear;
  assign rd_en    = (state_q == V_CNT) && (ptr_q < size_i);
  assign widx_inc = SZ_W'(widx_q) + SZ_W'(1);
  assign v        = (c1_q > c0_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[widx_q] <= req_i.vote;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[ptr_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    widx_d  = widx_q;
    fill_d  = fill_q;
    ptr_d   = ptr_q;
    c0_d    = c0_q;
    c1_d    = c1_q;
    known_d = known_q;
    last_d  = last_q;
    rvld_d  = 1'b0;
    rsp_d   = '0;
    case (state_q)
      V_IDLE: begin
        if (req_i.clear) begin
          widx_d  = '0;
          fill_d  = '0;
          known_d = 1'b0;
          last_d  = 1'b0;
        end else if (req_i.push) begin
          widx_d = (widx_inc >= size_i) ? '0 : widx_inc[IDX_W-1:0];
          fill_d = (fill_q < size_i) ? fill_q + SZ_W'(1) : fill_q;
          if (fill_d < size_i) begin
            rsp_d.done = 1'b1;
          end else begin
            state_d = V_CNT;
            ptr_d   = '0;
            c0_d    = '0;
            c1_d    = '0;
          end
        end
      end
      V_CNT: begin
        rvld_d = rd_en;
        if (rd_en) begin
          ptr_d = ptr_q + SZ_W'(1);
        end
        if (rvld_q) begin
          if (rd_q == supd_pkg::VOTE_ZERO) begin
            c0_d = c0_q + SZ_W'(1);
          end else if (rd_q == supd_pkg::VOTE_ONE) begin
            c1_d = c1_q + SZ_W'(1);
          end
        end
        if (!rd_en && !rvld_q) begin
          state_d = V_DEC;
        end
      end
      V_DEC: begin
        if (!known_q || (v != last_q)) begin
          rsp_d.emit  = 1'b1;
          rsp_d.level = v;
          last_d      = v;
          known_d     = 1'b1;
        end
        rsp_d.done = 1'b1;
        state_d    = V_IDLE;
      end
      default: begin
        state_d = V_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= V_IDLE;
      widx_q  <= '0;
      fill_q  <= '0;
      ptr_q   <= '0;
      c0_q    <= '0;
      c1_q    <= '0;
      known_q <= 1'b0;
      last_q  <= 1'b0;
      rvld_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      known_q <= known_d;
      last_q  <= last_d;
      rvld_q  <= rvld_d;
      rsp_q   <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> src/step_unit_pulse_debouncer.sv
// Top level: step accumulator, adaptive threshold and calibration sequencer.
// Depends on supd_pkg and supd_vote.
//
// Channel  | Dir | Signals                | Payload
// ---------+-----+------------------------+---------------------------------------
// s_axis   | in  | tvalid, tready, tdata  | command, step_count, step_direction,
//          |     | tuser                  | raw_level
// m_axis   | out | tvalid, tready, tdata  | status, filtered_level, new_target,
//          |     | tuser                  | pending_steps, calibrating
// cfg      | in  | cfg_we_i/idx_i/data_i  | one register write per cycle
//
// One transaction at a time; s_axis_tready is high only while the sequencer is idle.
// Commands other than step/signal pass from accept through S_EXEC and S_OUT to the result.
// A step that reaches the threshold, or a signal command, counts the votes when the
// window is full: the vote memory is read one entry per cycle.
// The shared 24x8 multiplier forms target*ratio and the average blend in turn.
// The result register frees the input side while m_axis is stalled. No clearing pass.

module step_unit_pulse_debouncer #(
  parameter int unsigned WINDOW_DEPTH = supd_pkg::WINDOW_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] step_count, [17:16] step_direction, [25:18] raw_level, [31:26] zero
  input  logic [supd_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // [2:0] command
  input  logic [supd_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] filtered_level, [16:1] new_target, [36:17] pending_steps,
  // [37] calibrating, [39:38] zero
  output logic [supd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // [2:0] status
  output logic [supd_pkg::STATUS_W-1:0]        m_axis_tuser,
  input  logic                                 cfg_we_i,
  input  logic [supd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [supd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned SZ_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXEC = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_BND  = 9'b000001000,
    S_THR  = 9'b000010000,
    S_VOTE = 9'b000100000,
    S_AVGM = 9'b001000000,
    S_AVG  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  // configuration
  logic [supd_pkg::TGT_W-1:0]   spu_q;
  logic [supd_pkg::TGT_W-1:0]   maxdev_q;
  logic                         adapt_q;
  logic [supd_pkg::RATIO_W-1:0] ratio_q;
  logic [supd_pkg::DWIN_W-1:0]  dwin_q;
  logic [supd_pkg::STEP_W-1:0]  clen_q;

  state_e                        state_q, state_d;
  supd_pkg::cmd_e                cmd_q, cmd_d;
  logic [supd_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [supd_pkg::DIR_W-1:0]    dir_q, dir_d;
  logic [supd_pkg::RAW_W-1:0]    raw_q, raw_d;
  logic [supd_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [supd_pkg::TGT_W-1:0]    tgt_q, tgt_d;
  logic [supd_pkg::AVG_W-1:0]    avg_q, avg_d;
  logic [supd_pkg::ECNT_W-1:0]   ec_q, ec_d;
  logic                          cal_q, cal_d;
  logic [supd_pkg::STEP_W-1:0]   cal_steps_q, cal_steps_d;
  logic [supd_pkg::MUL_W-1:0]    mul_q, mul_d;
  logic [supd_pkg::AVG_W-1:0]    lo_q, lo_d;
  logic [supd_pkg::AVG_W:0]      hi_q, hi_d;
  supd_pkg::status_e             res_status_q, res_status_d;
  logic                          res_level_q, res_level_d;
  logic [supd_pkg::TGT_W-1:0]    res_newt_q, res_newt_d;
  logic                          m_valid_q, m_valid_d;
  logic [supd_pkg::M_TDATA_W-1:0] m_tdata_q, m_tdata_d;
  supd_pkg::status_e             m_tuser_q, m_tuser_d;

  logic [supd_pkg::MUL_A_W-1:0]  mul_a;
  logic [supd_pkg::MUL_B_W-1:0]  mul_b;
  logic [supd_pkg::MUL_W-1:0]    mul_p;

  logic [SZ_W-1:0]               win_size;
  supd_pkg::vote_req_t           vreq;
  supd_pkg::vote_rsp_t           vrsp;
  supd_pkg::vote_e               vote;

  logic [supd_pkg::STEP_W:0]     cal_sum;
  logic [supd_pkg::STEP_W-1:0]   cal_sat;
  logic [supd_pkg::ACC_W:0]      acc_sum;
  logic [supd_pkg::AVG_W-1:0]    tgt_sh;
  logic [supd_pkg::AVG_W:0]      avg_ext;
  logic [supd_pkg::AVG_W:0]      clamp;
  logic [supd_pkg::TGT_W:0]      clamp_int;
  logic [supd_pkg::TGT_W-1:0]    thr;
  logic [supd_pkg::ACC_W-1:0]    tgt_ext;
  logic [supd_pkg::ACC_W-1:0]    dev;
  logic [supd_pkg::STEP_W-1:0]   steps_sat;
  logic [supd_pkg::AVG_W:0]      avg_blend;
  logic                          in_acc;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spu_q    <= supd_pkg::SPU_RST;
      maxdev_q <= supd_pkg::MAXDEV_RST;
      adapt_q  <= supd_pkg::ADAPT_RST;
      ratio_q  <= supd_pkg::RATIO_RST;
      dwin_q   <= supd_pkg::DWIN_RST;
      clen_q   <= supd_pkg::CLEN_RST;
    end else if (cfg_we_i) begin
      case (supd_pkg::cfg_idx_e'(cfg_idx_i))
        supd_pkg::CFG_SPU:    spu_q    <= cfg_data_i;
        supd_pkg::CFG_MAXDEV: maxdev_q <= cfg_data_i;
        supd_pkg::CFG_ADAPT:  adapt_q  <= cfg_data_i[0];
        supd_pkg::CFG_RATIO:  ratio_q  <= cfg_data_i[supd_pkg::RATIO_W-1:0];
        supd_pkg::CFG_DWIN:   dwin_q   <= cfg_data_i[supd_pkg::DWIN_W-1:0];
        supd_pkg::CFG_CLEN:   clen_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // window size clamped to 1..WINDOW_DEPTH
  always_comb begin
    if (dwin_q == '0) begin
      win_size = SZ_W'(1);
    end else if (32'(dwin_q) > 32'(WINDOW_DEPTH)) begin
      win_size = SZ_W'(WINDOW_DEPTH);
    end else begin
      win_size = SZ_W'(dwin_q);
    end
  end

  always_comb begin
    if (raw_q == supd_pkg::RAW_W'(0)) begin
      vote = supd_pkg::VOTE_ZERO;
    end else if (raw_q == supd_pkg::RAW_W'(1)) begin
      vote = supd_pkg::VOTE_ONE;
    end else begin
      vote = supd_pkg::VOTE_ABSTAIN;
    end
  end

  // shared multiplier
  always_comb begin
    if (state_q == S_AVGM) begin
      mul_a = avg_q;
      mul_b = supd_pkg::ALPHA_INV_Q8;
    end else begin
      mul_a = supd_pkg::MUL_A_W'(tgt_q);
      mul_b = ratio_q;
    end
  end
  assign mul_p = supd_pkg::MUL_W'(mul_a) * supd_pkg::MUL_W'(mul_b);

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign cal_sum   = {1'b0, cal_steps_q} + {1'b0, cnt_q};
  assign cal_sat   = cal_sum[supd_pkg::STEP_W] ? supd_pkg::STEP_MAX
                                               : cal_sum[supd_pkg::STEP_W-1:0];
  assign acc_sum   = {1'b0, acc_q} + (supd_pkg::ACC_W + 1)'(cnt_q);
  assign tgt_sh    = {tgt_q, 8'd0};
  assign avg_ext   = {1'b0, avg_q};
  assign tgt_ext   = supd_pkg::ACC_W'(tgt_q);
  assign dev       = (acc_q > tgt_ext) ? acc_q - tgt_ext : tgt_ext - acc_q;
  assign steps_sat = (acc_q > supd_pkg::ACC_W'(supd_pkg::STEP_MAX)) ? supd_pkg::STEP_MAX
                                                                  : acc_q[supd_pkg::STEP_W-1:0];
  assign avg_blend = (supd_pkg::AVG_W + 1)'(steps_sat) *
                     (supd_pkg::AVG_W + 1)'(supd_pkg::ALPHA_Q8) +
                     {1'b0, mul_q[supd_pkg::MUL_W-1:8]};

  // clamped average threshold, or the target while adaptation does not apply
  always_comb begin
    if (avg_ext < {1'b0, lo_q}) begin
      clamp = {1'b0, lo_q};
    end else if (avg_ext > hi_q) begin
      clamp = hi_q;
    end else begin
      clamp = avg_ext;
    end
    clamp_int = clamp[supd_pkg::AVG_W:8];
    if (adapt_q && (avg_q != '0) && (ec_q >= supd_pkg::ECNT_W'(2))) begin
      thr = clamp_int[supd_pkg::TGT_W] ? supd_pkg::TGT_MAX : clamp_int[supd_pkg::TGT_W-1:0];
    end else begin
      thr = tgt_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    dir_d        = dir_q;
    raw_d        = raw_q;
    acc_d        = acc_q;
    tgt_d        = tgt_q;
    avg_d        = avg_q;
    ec_d         = ec_q;
    cal_d        = cal_q;
    cal_steps_d  = cal_steps_q;
    mul_d        = mul_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_level_d  = res_level_q;
    res_newt_d   = res_newt_q;
    m_valid_d    = m_valid_q;
    m_tdata_d    = m_tdata_q;
    m_tuser_d    = m_tuser_q;
    vreq         = '0;
    vreq.vote    = vote;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = supd_pkg::cmd_e'(s_axis_tuser);
          cnt_d   = s_axis_tdata[15:0];
          dir_d   = s_axis_tdata[17:16];
          raw_d   = s_axis_tdata[25:18];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = supd_pkg::ST_NONE;
        res_level_d  = 1'b0;
        res_newt_d   = '0;
        state_d      = S_OUT;
        case (cmd_q)
          supd_pkg::CMD_STEP: begin
            if (cal_q) begin
              cal_steps_d = cal_sat;
              if (cal_sat >= clen_q) begin
                cal_d = 1'b0;
              end
            end
            if (dir_q == 2'b01) begin
              acc_d = acc_sum[supd_pkg::ACC_W] ? supd_pkg::ACC_MAX
                                               : acc_sum[supd_pkg::ACC_W-1:0];
            end else if (dir_q[1]) begin
              acc_d = (acc_q >= supd_pkg::ACC_W'(cnt_q)) ? acc_q - supd_pkg::ACC_W'(cnt_q)
                                                          : '0;
            end
            state_d = S_MUL;
          end
          supd_pkg::CMD_SIGNAL: begin
            vreq.push = 1'b1;
            state_d   = S_VOTE;
          end
          supd_pkg::CMD_CAL_START: begin
            cal_d       = 1'b1;
            cal_steps_d = '0;
          end
          supd_pkg::CMD_CAL_FINISH: begin
            cal_d = 1'b0;
            if (avg_q != '0) begin
              tgt_d        = avg_q[supd_pkg::AVG_W-1:8];
              res_newt_d   = avg_q[supd_pkg::AVG_W-1:8];
              res_status_d = supd_pkg::ST_CAL_UPD;
            end else begin
              res_status_d = supd_pkg::ST_CAL_REJECT;
            end
          end
          supd_pkg::CMD_RESET: begin
            acc_d       = '0;
            tgt_d       = spu_q;
            avg_d       = '0;
            ec_d        = '0;
            cal_d       = 1'b0;
            cal_steps_d = '0;
            vreq.clear  = 1'b1;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        mul_d   = mul_p;
        state_d = S_BND;
      end
      S_BND: begin
        lo_d    = tgt_sh - mul_q[supd_pkg::AVG_W-1:0];
        hi_d    = {1'b0, tgt_sh} + {1'b0, mul_q[supd_pkg::AVG_W-1:0]};
        state_d = S_THR;
      end
      S_THR: begin
        if (acc_q >= supd_pkg::ACC_W'(thr)) begin
          vreq.push = 1'b1;
          state_d   = S_VOTE;
        end else begin
          state_d = S_OUT;
        end
      end
      S_VOTE: begin
        if (vrsp.done) begin
          state_d = S_OUT;
          if (vrsp.emit) begin
            res_level_d = vrsp.level;
            ec_d        = (ec_q == supd_pkg::ECNT_MAX) ? ec_q : ec_q + supd_pkg::ECNT_W'(1);
            if (cmd_q == supd_pkg::CMD_STEP) begin
              res_status_d = (dev > supd_pkg::ACC_W'(maxdev_q)) ? supd_pkg::ST_DEV_ERR
                                                                 : supd_pkg::ST_SIGNAL;
              state_d      = S_AVGM;
            end else begin
              res_status_d = supd_pkg::ST_SIGNAL;
            end
          end
        end
      end
      S_AVGM: begin
        mul_d   = mul_p;
        state_d = S_AVG;
      end
      S_AVG: begin
        if (avg_q == '0) begin
          avg_d = {steps_sat, 8'd0};
        end else begin
          avg_d = avg_blend[supd_pkg::AVG_W-1:0];
        end
        acc_d   = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_tdata_d = {2'b00, cal_q, acc_q, res_newt_q, res_level_q};
          m_tuser_d = res_status_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      tgt_q       <= supd_pkg::SPU_RST;
      avg_q       <= '0;
      ec_q        <= '0;
      cal_q       <= 1'b0;
      cal_steps_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      tgt_q       <= tgt_d;
      avg_q       <= avg_d;
      ec_q        <= ec_d;
      cal_q       <= cal_d;
      cal_steps_q <= cal_steps_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    cnt_q        <= cnt_d;
    dir_q        <= dir_d;
    raw_q        <= raw_d;
    mul_q        <= mul_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_level_q  <= res_level_d;
    res_newt_q   <= res_newt_d;
    m_tdata_q    <= m_tdata_d;
    m_tuser_q    <= m_tuser_d;
  end

  supd_vote #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_vote (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (vreq),
    .size_i (win_size),
    .rsp_o  (vrsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

>>> tb/step_unit_pulse_debouncer_test.sv
`timescale 1ns / 100ps

// Self-checking testbench for step_unit_pulse_debouncer: a scoreboard class predicts each
// result from the accepted input transactions while the stream sides idle at random.
// Depends on supd_pkg and the block's RTL.

module step_unit_pulse_debouncer_test;
  import supd_pkg::*;

  localparam int unsigned ITEM_GOAL   = 1650;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned REPORT_MAX  = 200;

  typedef struct {
    status_e          status;
    logic             level;
    logic [TGT_W-1:0] new_target;
    logic [ACC_W-1:0] pending;
    logic             calibrating;
  } unit_result_t;

  class debounce_scoreboard;
    logic [15:0]        spu, max_dev, cal_len;
    logic               adapt;
    logic [RATIO_W-1:0] ratio;
    logic [DWIN_W-1:0]  dwin;

    logic [ACC_W-1:0]   acc;
    logic [TGT_W-1:0]   target;
    logic [AVG_W-1:0]   avg;
    logic [ECNT_W-1:0]  emitted;
    logic               cal_on;
    int unsigned        cal_steps;
    vote_e              votes[WINDOW_DEPTH];
    int unsigned        widx, wfill;
    logic               known, last_level;

    unit_result_t       expected_units[$];
    int unsigned        errors;

    function new();
      spu     = SPU_RST;
      max_dev = MAXDEV_RST;
      adapt   = ADAPT_RST;
      ratio   = RATIO_RST;
      dwin    = DWIN_RST;
      cal_len = CLEN_RST;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      acc       = '0;
      target    = spu;
      avg       = '0;
      emitted   = '0;
      cal_on    = 1'b0;
      cal_steps = 0;
      foreach (votes[i]) votes[i] = VOTE_ZERO;
      widx       = 0;
      wfill      = 0;
      known      = 1'b0;
      last_level = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_SPU:    spu = value;
        CFG_MAXDEV: max_dev = value;
        CFG_ADAPT:  adapt = value[0];
        CFG_RATIO:  ratio = value[RATIO_W-1:0];
        CFG_DWIN:   dwin = value[DWIN_W-1:0];
        CFG_CLEN:   cal_len = value;
        default: ;
      endcase
    endfunction

    function int unsigned win_size();
      if (dwin == 0) return 1;
      if (dwin > WINDOW_DEPTH) return WINDOW_DEPTH;
      return dwin;
    endfunction

    // Majority vote; returns 1 when the debounced level is first known or changes.
    function bit push_vote(logic [RAW_W-1:0] raw, output logic lvl);
      int unsigned size, zeros, ones;
      logic v;
      lvl   = 1'b0;
      size  = win_size();
      zeros = 0;
      ones  = 0;
      if (widx < WINDOW_DEPTH) begin
        if (raw == 0) votes[widx] = VOTE_ZERO;
        else if (raw == 1) votes[widx] = VOTE_ONE;
        else votes[widx] = VOTE_ABSTAIN;
      end
      widx++;
      if (widx >= size) widx = 0;
      if (wfill < size) wfill++;
      if (wfill < size) return 1'b0;
      for (int i = 0; i < size; i++) begin
        if (votes[i] == VOTE_ZERO) zeros++;
        else if (votes[i] == VOTE_ONE) ones++;
      end
      v = (ones > zeros);
      if (!known || v != last_level) begin
        last_level = v;
        known      = 1'b1;
        lvl        = v;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void accept_event(logic [CMD_W-1:0] cmd, logic [STEP_W-1:0] cnt,
                               logic [DIR_W-1:0] dir, logic [RAW_W-1:0] raw);
      unit_result_t    r;
      logic            lvl;
      logic [31:0]     thr, tol, lo, hi, clamped, actual, diff, unit;
      longint unsigned blend;
      r = '{status: ST_NONE, level: 1'b0, new_target: '0, pending: '0, calibrating: 1'b0};
      lvl = 1'b0;
      case (cmd)
        CMD_STEP: begin
          if (cal_on) begin
            cal_steps += cnt;
            if (cal_steps > STEP_MAX) cal_steps = STEP_MAX;
            if (cal_steps >= cal_len) cal_on = 1'b0;
          end
          if (dir == 2'd1) begin
            if (32'(acc) + cnt > ACC_MAX) acc = ACC_MAX;
            else acc = acc + cnt;
          end else if (dir[1]) begin
            acc = (acc >= cnt) ? acc - cnt : '0;
          end
          thr = target;
          if (adapt && avg != 0 && emitted >= 2) begin
            tol     = 32'(target) * ratio;
            lo      = (32'(target) << 8) - tol;
            hi      = (32'(target) << 8) + tol;
            clamped = avg;
            if (clamped < lo) clamped = lo;
            else if (clamped > hi) clamped = hi;
            clamped = clamped >> 8;
            thr = (clamped > TGT_MAX) ? 32'(TGT_MAX) : clamped;
          end
          if (acc >= thr && push_vote(raw, lvl)) begin
            actual = acc;
            diff   = (actual > target) ? actual - target : target - actual;
            acc    = '0;
            unit   = (actual > STEP_MAX) ? 32'(STEP_MAX) : actual;
            if (avg == 0) begin
              avg = AVG_W'(unit << 8);
            end else begin
              blend = 64'(ALPHA_Q8) * (64'(unit) << 8) + 64'(ALPHA_INV_Q8) * avg;
              avg   = AVG_W'(blend >> 8);
            end
            if (emitted != ECNT_MAX) emitted++;
            r.level = lvl;
            if (diff > max_dev) r.status = ST_DEV_ERR;
            else r.status = ST_SIGNAL;
          end
        end
        CMD_SIGNAL: begin
          if (push_vote(raw, lvl)) begin
            if (emitted != ECNT_MAX) emitted++;
            r.level  = lvl;
            r.status = ST_SIGNAL;
          end
        end
        CMD_CAL_START: begin
          cal_on    = 1'b1;
          cal_steps = 0;
        end
        CMD_CAL_FINISH: begin
          cal_on = 1'b0;
          if (avg != 0) begin
            target       = avg[AVG_W-1:8];
            r.new_target = target;
            r.status     = ST_CAL_UPD;
          end else begin
            r.status = ST_CAL_REJECT;
          end
        end
        CMD_RESET: restart();
        default: ;
      endcase
      r.pending     = acc;
      r.calibrating = cal_on;
      expected_units.push_back(r);
    endfunction

    function void field_check(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_unit(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] data);
      unit_result_t want;
      if (expected_units.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t unexpected transaction: expected none, actual status %0h data %0h",
                   $time, st, data);
        return;
      end
      want = expected_units.pop_front();
      field_check("status", 32'(want.status), 32'(st));
      field_check("filtered_level", 32'(want.level), 32'(data[0]));
      field_check("new_target", 32'(want.new_target), 32'(data[16:1]));
      field_check("pending_steps", 32'(want.pending), 32'(data[36:17]));
      field_check("calibrating", 32'(want.calibrating), 32'(data[37]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  debounce_scoreboard board = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  logic        level_now = 1'b0;
  int unsigned cycles = 0;
  int unsigned rx_left = 0, rx_mode = 0, rx_phase = 0, rx_period = 2, rx_duty = 1;

  step_unit_pulse_debouncer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_left   = $urandom_range(50, 400);
      rx_mode   = $urandom_range(0, 3);
      rx_period = $urandom_range(2, 24);
      rx_duty   = $urandom_range(1, rx_period - 1);
      rx_phase  = 0;
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = $urandom_range(0, 1);
      2: m_axis_tready = ($urandom_range(0, 4) == 0);
      default: m_axis_tready = (rx_phase % rx_period) < rx_duty;
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_unit(m_axis_tuser, m_axis_tdata);
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic idle_gap(input int unsigned n);
    s_axis_tvalid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (board.expected_units.size() != 0) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [STEP_W-1:0] cnt,
                           input logic [DIR_W-1:0] dir, input logic [RAW_W-1:0] raw);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!steady)
        idle_gap($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 20));
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {6'b0, raw, dir, cnt};
    do @(posedge clk_i); while (!s_axis_tready);
    board.accept_event(cmd, cnt, dir, raw);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    board.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned typ_lo, int unsigned typ_hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  // A grown window is restarted so that no vote reads an entry never written.
  task automatic configure(input bit all_regs);
    int unsigned old_size;
    drain();
    old_size = board.win_size();
    if (all_regs || $urandom_range(0, 1)) write_reg(CFG_SPU, pick_value(1, 65535, 2, 400));
    if (all_regs || $urandom_range(0, 1)) write_reg(CFG_MAXDEV, pick_value(0, 65535, 0, 60));
    if (all_regs || $urandom_range(0, 1)) write_reg(CFG_ADAPT, $urandom_range(0, 1));
    if (all_regs || $urandom_range(0, 1)) write_reg(CFG_RATIO, pick_value(0, 255, 1, 254));
    if (all_regs || $urandom_range(0, 1)) write_reg(CFG_DWIN, pick_value(0, 31, 1, 16));
    if (all_regs || $urandom_range(0, 1)) write_reg(CFG_CLEN, pick_value(0, 65535, 1, 3000));
    if (board.win_size() > old_size || $urandom_range(0, 1))
      send_item(CMD_RESET, $urandom, $urandom, $urandom);
  endtask

  task automatic send_random_item();
    int unsigned pick, base, size, lo, hi;
    logic [RAW_W-1:0] raw;
    size = board.win_size();
    base = board.target;
    if ($urandom_range(0, 2 * size + 3) == 0) level_now = ~level_now;
    raw  = ($urandom_range(0, 99) < 85) ? RAW_W'(level_now) : RAW_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    lo   = base / 4;
    hi   = base + base / 2;
    if (hi > STEP_MAX) hi = STEP_MAX;
    if (pick < 52) send_item(CMD_STEP, $urandom_range(lo, hi), 2'b01, raw);
    else if (pick < 62)
      send_item(CMD_STEP, $urandom_range(0, base), $urandom_range(0, 1) ? 2'b11 : 2'b10, raw);
    else if (pick < 66) send_item(CMD_STEP, $urandom, 2'b00, raw);
    else if (pick < 78) send_item(CMD_SIGNAL, $urandom, $urandom, raw);
    else if (pick < 82) send_item(CMD_CAL_START, $urandom, $urandom, $urandom);
    else if (pick < 86) send_item(CMD_CAL_FINISH, $urandom, $urandom, $urandom);
    else if (pick < 88) send_item(CMD_RESET, $urandom, $urandom, $urandom);
    else if (pick < 90) send_item($urandom_range(5, 7), $urandom, $urandom, $urandom);
    else send_item($urandom_range(0, 7), $urandom, $urandom, $urandom);
  endtask

  initial begin
    bit          first;
    int unsigned phase_len;
    first = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, target 200, window of 5
    send_item(CMD_CAL_FINISH, 16'd0, 2'b00, 8'd0);
    send_item(3'd5, STEP_MAX, 2'b11, 8'hFF);
    send_item(3'd6, 16'd0, 2'b00, 8'd0);
    send_item(3'd7, 16'h5A5A, 2'b10, 8'h80);
    send_item(CMD_CAL_START, 16'd0, 2'b00, 8'd0);
    send_item(CMD_STEP, 16'd0, 2'b00, 8'd0);
    send_item(CMD_STEP, 16'd600, 2'b01, 8'd1);
    send_item(CMD_STEP, 16'd500, 2'b01, 8'd1);
    send_item(CMD_STEP, 16'd0, 2'b00, 8'hFF);
    send_item(CMD_STEP, 16'd0, 2'b10, 8'd0);
    send_item(CMD_STEP, 16'd0, 2'b01, 8'd2);
    send_item(CMD_STEP, 16'd150, 2'b01, 8'd0);
    send_item(CMD_STEP, STEP_MAX, 2'b11, 8'd0);
    send_item(CMD_STEP, 16'd190, 2'b01, 8'd0);
    send_item(CMD_STEP, 16'd300, 2'b10, 8'd0);
    send_item(CMD_SIGNAL, 16'd0, 2'b00, 8'd0);
    send_item(CMD_SIGNAL, STEP_MAX, 2'b11, 8'd1);
    send_item(CMD_SIGNAL, 16'd0, 2'b00, 8'd1);
    send_item(CMD_STEP, 16'd205, 2'b01, 8'd0);
    send_item(CMD_CAL_FINISH, STEP_MAX, 2'b11, 8'hFF);
    send_item(CMD_RESET, STEP_MAX, 2'b11, 8'hFF);
    send_item(CMD_STEP, STEP_MAX, 2'b01, 8'hFE);

    while (items_sent < ITEM_GOAL) begin
      configure(first);
      first     = 1'b0;
      steady    = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(80, 160);
      repeat (phase_len) begin
        if ($urandom_range(0, 249) == 0)
          repeat (24) send_item(CMD_STEP, STEP_MAX, 2'b01, RAW_W'(level_now));
        else if ($urandom_range(0, 149) == 0)
          drain();
        else
          send_random_item();
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (board.errors == 0 && board.expected_units.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
src/supd_pkg.sv
src/supd_vote.sv
src/step_unit_pulse_debouncer.sv
tb/step_unit_pulse_debouncer_test.sv
